// File: design/cbb_pkg.sv
// Shared types and constants of the content bounding box unit.
// Used by the front end, the queue, the back end and the top level.
// No dependencies.
package cbb_pkg;

    // Raster bounds; pixels beyond them never count as content
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Coordinate widths (a content pixel lies below the bound)
    localparam int XC_W = $clog2(MAX_WIDTH);
    localparam int YC_W = $clog2(MAX_HEIGHT);
    // Count widths (a count may reach the bound itself)
    localparam int XN_W = $clog2(MAX_WIDTH + 1);
    localparam int YN_W = $clog2(MAX_HEIGHT + 1);

    // Pixel, register and result field widths
    localparam int PIX_W    = 8;
    localparam int PAD_W    = 8;
    localparam int BOX_XY_W = 12;
    localparam int BOX_WH_W = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PAD_MARGIN     = CFG_IDX_W'(1);
    localparam logic [PIX_W-1:0] DARK_THRESHOLD_RST = PIX_W'(240);
    localparam logic [PAD_W-1:0] PAD_MARGIN_RST     = PAD_W'(10);

    // Luma weights, 14 fractional bits, with rounding term
    localparam int PROD_W = 22;
    localparam int SUM_W  = 23;
    localparam int GRAY_SHIFT = 14;
    localparam logic [PROD_W-1:0] GRAY_KB = PROD_W'(1868);
    localparam logic [PROD_W-1:0] GRAY_KG = PROD_W'(9617);
    localparam logic [PROD_W-1:0] GRAY_KR = PROD_W'(4899);
    localparam logic [SUM_W-1:0]  GRAY_RND = SUM_W'(8192);

    // Queue between front and back end
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified pixel as handed from front to back end
    typedef struct packed {
        logic            content;
        logic [XC_W-1:0] col;
        logic [YC_W-1:0] row;
        logic            frame_end;
        logic [XN_W-1:0] cols;
        logic [YN_W-1:0] rows;
    } cbb_item_t;

endpackage

// File: design/content_bounding_box_unit.sv
// Content bounding box unit: takes a BGR raster one pixel per transaction,
// with row-end and frame-end marks, and after each frame returns the padded
// box around all pixels whose gray level is at or below dark_threshold.
// A pixel is taken every clock while the queue has room; nothing in the
// pixel path iterates. The front end holds one product stage and feeds a
// four-entry queue; the back end folds each popped pixel into the extent.
// At frame end the result passes the final extent stage, the padded stage
// and the output register, held there until the result channel takes it.
// Frame width is the length of the first row; an empty frame reports a box
// of twice the margin from 0,0 (clamped) with content_found low.
// Configuration: index 0 dark_threshold, index 1 pad_margin; write only
// while the block is idle. Depends on cbb_pkg, cbb_front, cbb_fifo, cbb_back.
module content_bounding_box_unit
    import cbb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_blue,
    input  logic [PIX_W-1:0]      s_green,
    input  logic [PIX_W-1:0]      s_red,
    input  logic                  s_row_end,
    input  logic                  s_frame_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BOX_XY_W-1:0]   m_box_x,
    output logic [BOX_XY_W-1:0]   m_box_y,
    output logic [BOX_WH_W-1:0]   m_box_w,
    output logic [BOX_WH_W-1:0]   m_box_h,
    output logic                  m_content_found
);

    logic [PIX_W-1:0] thr_reg, thr_next;
    logic [PAD_W-1:0] pad_reg, pad_next;

    logic      push_valid, push_ready;
    cbb_item_t push_item;
    logic      pop_valid, pop_ready;
    cbb_item_t pop_item;

    // Configuration register decode
    assign cfg_ready = 1'b1;

    always_comb begin
        thr_next = thr_reg;
        pad_next = pad_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DARK_THRESHOLD: thr_next = PIX_W'(cfg_data);
                REG_PAD_MARGIN:     pad_next = PAD_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= DARK_THRESHOLD_RST;
            pad_reg <= PAD_MARGIN_RST;
        end else begin
            thr_reg <= thr_next;
            pad_reg <= pad_next;
        end
    end

    cbb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .dark_threshold (thr_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_blue         (s_blue),
        .s_green        (s_green),
        .s_red          (s_red),
        .s_row_end      (s_row_end),
        .s_frame_end    (s_frame_end),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    cbb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    cbb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pad_margin      (pad_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_box_x         (m_box_x),
        .m_box_y         (m_box_y),
        .m_box_w         (m_box_w),
        .m_box_h         (m_box_h),
        .m_content_found (m_content_found)
    );

endmodule

// File: design/cbb_front.sv
// Front end: pixel intake, raster position tracking and gray classification.
// Depends on cbb_pkg.
module cbb_front
    import cbb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [PIX_W-1:0] dark_threshold,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_blue,
    input  logic [PIX_W-1:0] s_green,
    input  logic [PIX_W-1:0] s_red,
    input  logic             s_row_end,
    input  logic             s_frame_end,
    output logic             push_valid,
    input  logic             push_ready,
    output cbb_item_t        push_item
);

    logic [XN_W-1:0] col_cnt_reg, col_cnt_next;
    logic [YN_W-1:0] row_cnt_reg, row_cnt_next;
    logic [XN_W-1:0] fw_reg, fw_next;

    logic              p_valid_reg, p_valid_next;
    logic [PROD_W-1:0] p_prod_b_reg, p_prod_g_reg, p_prod_r_reg;
    logic              p_inside_reg;
    logic [XC_W-1:0]   p_col_reg;
    logic [YC_W-1:0]   p_row_reg;
    logic              p_fe_reg;
    logic [XN_W-1:0]   p_cols_reg;
    logic [YN_W-1:0]   p_rows_reg;

    logic              accept;
    logic [XN_W-1:0]   col_inc;
    logic [YN_W-1:0]   row_inc;
    logic              row_zero;
    logic              in_bounds;
    logic [SUM_W-1:0]  gray_sum;
    logic [PIX_W-1:0]  gray;

    assign s_ready = !p_valid_reg || push_ready;
    assign accept  = s_valid && s_ready;

    // Saturating position increments
    assign col_inc   = (col_cnt_reg == XN_W'(MAX_WIDTH))  ? col_cnt_reg : col_cnt_reg + 1'b1;
    assign row_inc   = (row_cnt_reg == YN_W'(MAX_HEIGHT)) ? row_cnt_reg : row_cnt_reg + 1'b1;
    assign row_zero  = (row_cnt_reg == '0);
    assign in_bounds = (col_cnt_reg < XN_W'(MAX_WIDTH)) && (row_cnt_reg < YN_W'(MAX_HEIGHT))
                       && (row_zero || (col_cnt_reg < fw_reg));

    // Raster position counters
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        fw_next      = fw_reg;
        if (accept) begin
            if (s_frame_end) begin
                col_cnt_next = '0;
                row_cnt_next = '0;
                fw_next      = '0;
            end else if (s_row_end) begin
                if (row_zero) begin
                    fw_next = col_inc;
                end
                col_cnt_next = '0;
                row_cnt_next = row_inc;
            end else begin
                col_cnt_next = col_inc;
            end
        end
    end

    // Product stage occupancy
    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (push_ready) begin
            p_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            fw_reg      <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            fw_reg      <= fw_next;
            p_valid_reg <= p_valid_next;
        end
    end

    // Weighted channels and raster position of the accepted pixel
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_prod_b_reg <= PROD_W'(s_blue)  * GRAY_KB;
            p_prod_g_reg <= PROD_W'(s_green) * GRAY_KG;
            p_prod_r_reg <= PROD_W'(s_red)   * GRAY_KR;
            p_inside_reg <= in_bounds;
            p_col_reg    <= XC_W'(col_cnt_reg);
            p_row_reg    <= YC_W'(row_cnt_reg);
            p_fe_reg     <= s_frame_end;
            p_cols_reg   <= row_zero ? col_inc : fw_reg;
            p_rows_reg   <= row_inc;
        end
    end

    // Gray level and content decision
    assign gray_sum = SUM_W'(p_prod_b_reg) + SUM_W'(p_prod_g_reg) + SUM_W'(p_prod_r_reg)
                      + GRAY_RND;
    assign gray     = PIX_W'(gray_sum >> GRAY_SHIFT);

    assign push_valid          = p_valid_reg;
    assign push_item.content   = p_inside_reg && (gray <= dark_threshold);
    assign push_item.col       = p_col_reg;
    assign push_item.row       = p_row_reg;
    assign push_item.frame_end = p_fe_reg;
    assign push_item.cols      = p_cols_reg;
    assign push_item.rows      = p_rows_reg;

endmodule

// File: design/cbb_fifo.sv
// Short queue of classified pixels between front and back end.
// Depends on cbb_pkg.
module cbb_fifo
    import cbb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  cbb_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cbb_item_t pop_item
);

    cbb_item_t         slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/cbb_back.sv
// Back end: content extent tracking and padded box computation at frame end.
// Depends on cbb_pkg.
module cbb_back
    import cbb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [PAD_W-1:0]    pad_margin,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  cbb_item_t           pop_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BOX_XY_W-1:0] m_box_x,
    output logic [BOX_XY_W-1:0] m_box_y,
    output logic [BOX_WH_W-1:0] m_box_w,
    output logic [BOX_WH_W-1:0] m_box_h,
    output logic                m_content_found
);

    // Widths for padding arithmetic
    localparam int XP_W = (XC_W > PAD_W) ? XC_W : PAD_W;
    localparam int YP_W = (YC_W > PAD_W) ? YC_W : PAD_W;
    localparam int XS_W = ((XN_W > PAD_W + 1) ? XN_W : PAD_W + 1) + 1;
    localparam int YS_W = ((YN_W > PAD_W + 1) ? YN_W : PAD_W + 1) + 1;

    // Running extent of the current frame
    logic [XC_W-1:0] min_col_reg, min_col_next, max_col_reg, max_col_next;
    logic [YC_W-1:0] min_row_reg, min_row_next, max_row_reg, max_row_next;
    logic            seen_reg, seen_next;

    // Final extent stage
    logic            fin_valid_reg, fin_valid_next;
    logic [XC_W-1:0] fin_minc_reg, fin_maxc_reg;
    logic [YC_W-1:0] fin_minr_reg, fin_maxr_reg;
    logic            fin_seen_reg;
    logic [XN_W-1:0] fin_cols_reg;
    logic [YN_W-1:0] fin_rows_reg;

    // Padded stage
    logic            pad_valid_reg, pad_valid_next;
    logic [XC_W-1:0] pad_x_reg;
    logic [YC_W-1:0] pad_y_reg;
    logic [XS_W-1:0] pad_spanx_reg;
    logic [YS_W-1:0] pad_spany_reg;
    logic [XN_W-1:0] pad_cols_reg;
    logic [YN_W-1:0] pad_rows_reg;
    logic            pad_seen_reg;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [BOX_XY_W-1:0] m_box_x_reg, m_box_y_reg;
    logic [BOX_WH_W-1:0] m_box_w_reg, m_box_h_reg;
    logic                m_found_reg;

    logic            pop, pad_adv, fin_adv, out_free;
    logic            hit;
    logic [XC_W-1:0] mrg_minc, mrg_maxc;
    logic [YC_W-1:0] mrg_minr, mrg_maxr;
    logic [XC_W-1:0] bx;
    logic [YC_W-1:0] by;
    logic [XP_W-1:0] bx_ext, padx_ext;
    logic [YP_W-1:0] by_ext, pady_ext;
    logic [XC_W-1:0] px;
    logic [YC_W-1:0] py;
    logic [XS_W-1:0] spanx;
    logic [YS_W-1:0] spany;
    logic [XS_W-1:0] roomx;
    logic [YS_W-1:0] roomy;
    logic [XN_W-1:0] wx;
    logic [YN_W-1:0] hy;

    // Stage handshakes
    assign out_free  = !m_valid_reg || m_ready;
    assign pad_adv   = pad_valid_reg && out_free;
    assign fin_adv   = fin_valid_reg && (!pad_valid_reg || pad_adv);
    assign pop_ready = !fin_valid_reg || fin_adv;
    assign pop       = pop_valid && pop_ready;

    // Merge the head pixel into the extent
    assign hit      = pop_item.content;
    assign mrg_minc = (hit && (pop_item.col < min_col_reg)) ? pop_item.col : min_col_reg;
    assign mrg_maxc = (hit && (pop_item.col > max_col_reg)) ? pop_item.col : max_col_reg;
    assign mrg_minr = (hit && (pop_item.row < min_row_reg)) ? pop_item.row : min_row_reg;
    assign mrg_maxr = (hit && (pop_item.row > max_row_reg)) ? pop_item.row : max_row_reg;

    always_comb begin
        min_col_next   = min_col_reg;
        max_col_next   = max_col_reg;
        min_row_next   = min_row_reg;
        max_row_next   = max_row_reg;
        seen_next      = seen_reg;
        fin_valid_next = fin_valid_reg;
        if (fin_adv) begin
            fin_valid_next = 1'b0;
        end
        if (pop) begin
            if (pop_item.frame_end) begin
                // frame closes: extent restarts for the next one
                min_col_next   = '1;
                max_col_next   = '0;
                min_row_next   = '1;
                max_row_next   = '0;
                seen_next      = 1'b0;
                fin_valid_next = 1'b1;
            end else begin
                min_col_next = mrg_minc;
                max_col_next = mrg_maxc;
                min_row_next = mrg_minr;
                max_row_next = mrg_maxr;
                seen_next    = seen_reg || hit;
            end
        end
    end

    // Padded origin and unclamped size; an empty frame uses a box at 0,0
    assign bx       = fin_seen_reg ? fin_minc_reg : '0;
    assign by       = fin_seen_reg ? fin_minr_reg : '0;
    assign bx_ext   = XP_W'(bx);
    assign by_ext   = YP_W'(by);
    assign padx_ext = XP_W'(pad_margin);
    assign pady_ext = YP_W'(pad_margin);
    assign px       = (bx_ext > padx_ext) ? XC_W'(bx_ext - padx_ext) : '0;
    assign py       = (by_ext > pady_ext) ? YC_W'(by_ext - pady_ext) : '0;
    assign spanx    = fin_seen_reg
                      ? XS_W'(fin_maxc_reg) - XS_W'(fin_minc_reg) + 1'b1
                        + (XS_W'(pad_margin) << 1)
                      : (XS_W'(pad_margin) << 1);
    assign spany    = fin_seen_reg
                      ? YS_W'(fin_maxr_reg) - YS_W'(fin_minr_reg) + 1'b1
                        + (YS_W'(pad_margin) << 1)
                      : (YS_W'(pad_margin) << 1);

    // Clamp the size to the image
    assign roomx = XS_W'(pad_cols_reg - XN_W'(pad_x_reg));
    assign roomy = YS_W'(pad_rows_reg - YN_W'(pad_y_reg));
    assign wx    = (roomx < pad_spanx_reg) ? XN_W'(roomx) : XN_W'(pad_spanx_reg);
    assign hy    = (roomy < pad_spany_reg) ? YN_W'(roomy) : YN_W'(pad_spany_reg);

    always_comb begin
        pad_valid_next = pad_valid_reg;
        if (fin_adv) begin
            pad_valid_next = 1'b1;
        end else if (pad_adv) begin
            pad_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (pad_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            seen_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            pad_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            seen_reg      <= seen_next;
            fin_valid_reg <= fin_valid_next;
            pad_valid_reg <= pad_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (pop && pop_item.frame_end) begin
            fin_minc_reg <= mrg_minc;
            fin_maxc_reg <= mrg_maxc;
            fin_minr_reg <= mrg_minr;
            fin_maxr_reg <= mrg_maxr;
            fin_seen_reg <= seen_reg || hit;
            fin_cols_reg <= pop_item.cols;
            fin_rows_reg <= pop_item.rows;
        end
        if (fin_adv) begin
            pad_x_reg     <= px;
            pad_y_reg     <= py;
            pad_spanx_reg <= spanx;
            pad_spany_reg <= spany;
            pad_cols_reg  <= fin_cols_reg;
            pad_rows_reg  <= fin_rows_reg;
            pad_seen_reg  <= fin_seen_reg;
        end
        if (pad_adv) begin
            m_box_x_reg <= BOX_XY_W'(pad_x_reg);
            m_box_y_reg <= BOX_XY_W'(pad_y_reg);
            m_box_w_reg <= BOX_WH_W'(wx);
            m_box_h_reg <= BOX_WH_W'(hy);
            m_found_reg <= pad_seen_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_box_x         = m_box_x_reg;
    assign m_box_y         = m_box_y_reg;
    assign m_box_w         = m_box_w_reg;
    assign m_box_h         = m_box_h_reg;
    assign m_content_found = m_found_reg;

`ifndef NO_ASSERTIONS
    // a frame-end transaction always lands in the final extent stage
    a_frame_end_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && pop_item.frame_end |=> fin_valid_reg)
        else $error("frame end lost on its way to the final stage");

    // an empty frame leaves the extent at its cleared value
    a_empty_extent: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && !fin_seen_reg |-> fin_maxc_reg == '0 && fin_maxr_reg == '0)
        else $error("extent moved without any content");

    // a frame with content has an ordered extent
    a_ordered_extent: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && fin_seen_reg |->
            fin_minc_reg <= fin_maxc_reg && fin_minr_reg <= fin_maxr_reg)
        else $error("content extent out of order");

    // padded origin always lies inside the image
    a_origin_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_valid_reg |-> XN_W'(pad_x_reg) < pad_cols_reg && YN_W'(pad_y_reg) < pad_rows_reg)
        else $error("padded origin outside the image");
`endif

endmodule
